// File: hdl/lss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types and constants for the adjugate-based linear system solver.
// ----------------------------------------------------------------------------
package lss_pkg;

	localparam int MAX_SIZE_DEF = 4;
	localparam logic [2:0] SIZE_RESET = 3'd2;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_SINGULAR  = 2'd1;
	localparam logic [1:0] STATUS_SATURATED = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MASK,
		ST_COL,
		ST_FETCH,
		ST_MUL,
		ST_ACC,
		ST_STORE,
		ST_DET,
		ST_DIV,
		ST_EMIT,
		ST_SING
	} state_t;

endpackage

// File: hdl/linear_system_solver_adjugate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_system_solver_adjugate
// Solves A.x = b in signed Q16.16 by Cramer's rule with exact wide integers.
// ----------------------------------------------------------------------------
// Values are loaded one per cycle while busy is low: n*n coefficients row by
// row, then n right-hand-side values. After the last one busy rises and the
// block computes det(A) and each det(A_i) by a subset-minor expansion, using
// one shift-add multiplier (each term is fetched, multiplied and accumulated)
// and a minor memory of 2^MAX_SIZE wide entries; each quotient then comes from
// a W-bit restoring divider and is then emitted.
// Results come out one per strobe and cannot be held off by the receiver;
// a singular matrix gives one result with status singular. Writing
// system_size abandons any partial load.
// ----------------------------------------------------------------------------
module linear_system_solver_adjugate #(
	parameter int MAX_SIZE = lss_pkg::MAX_SIZE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               size_we,
	input  logic [2:0]         system_size,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] value,
	output logic               result_valid,
	output logic signed [31:0] solution,
	output logic [1:0]         unknown_index,
	output logic [1:0]         status,
	output logic               last
);

	localparam int M      = MAX_SIZE;
	localparam int W      = ((35 * M + 17) / 32 + 2) * 32;
	localparam int IW     = (M > 1) ? $clog2(M) : 1;
	localparam int NW     = $clog2(M + 1);
	localparam int ED     = M * M + M;
	localparam int AW     = (ED > 1) ? $clog2(ED) : 1;
	localparam int CW     = $clog2(W + 1);
	localparam int MD     = 2 ** M;
	localparam logic [AW-1:0] RHS_BASE = AW'(M * M);
	localparam logic [AW-1:0] ROW_STEP = AW'(M);

	lss_pkg::state_t state_q, state_d;

	logic [2:0]    size_q;
	logic [NW-1:0] n_eff;
	logic [NW-1:0] ld_row_q;
	logic [NW-1:0] ld_col_q;

	logic [IW-1:0] row_q;
	logic [M-1:0]  mask_q;
	logic [M-1:0]  full_mask;
	logic [M-1:0]  sub_mask;
	logic [NW-1:0] col_q;
	logic          pos_q;
	logic [IW-1:0] repl_q;
	logic          rhs_mode_q;
	logic [W-1:0]  acc_q;
	logic [W-1:0]  prod_q;
	logic [4:0]    k_q;
	logic          sub_zero_q;
	logic [W-1:0]  minor_rd_q;
	logic [31:0]   elem_rd_q;
	logic [W-1:0]  den_q;
	logic          den_neg_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  num_q;
	logic [31:0]   quo_q;
	logic          big_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;

	logic [W-1:0]  minor_mem [MD];
	logic [31:0]   elem_mem [ED];

	logic          accept;
	logic          load_last;
	logic [AW-1:0] ld_addr;
	logic [AW-1:0] rd_addr;
	logic [NW-1:0] pop;
	logic          pop_ok;
	logic          mask_end;
	logic          restart;
	logic          acc_zero;
	logic [W-1:0]  acc_abs;
	logic [W-1:0]  mc;
	logic [W-1:0]  addend;
	logic [W-1:0]  rem_sh;
	logic          rem_ge;
	logic          emit_last;

	// effective size clamped to 1..M
	always_comb begin
		if (size_q == 3'd0) begin
			n_eff = NW'(1);
		end else if (size_q > 3'(M)) begin
			n_eff = NW'(M);
		end else begin
			n_eff = NW'(size_q);
		end
	end

	always_comb begin
		pop = '0;
		for (int i = 0; i < M; i++) begin
			pop = pop + NW'(mask_q[i]);
		end
	end

	assign full_mask = M'((MD - 1) >> (M - int'(n_eff)));
	assign sub_mask  = mask_q & ~(M'(1) << col_q);
	assign pop_ok    = (pop == n_eff - NW'(row_q));
	assign mask_end  = (mask_q == full_mask);
	assign acc_zero  = (acc_q == '0);
	assign acc_abs   = acc_q[W-1] ? (~acc_q + W'(1)) : acc_q;
	assign mc        = sub_zero_q ? W'(1) : minor_rd_q;
	assign rem_sh    = {rem_q[W-2:0], num_q[W-1]};
	assign rem_ge    = (rem_sh >= den_q);
	assign emit_last = (NW'(repl_q) == n_eff - NW'(1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lss_pkg::ST_IDLE: begin
				if (accept && load_last) state_d = lss_pkg::ST_MASK;
			end
			lss_pkg::ST_MASK: begin
				if (pop_ok) state_d = lss_pkg::ST_COL;
			end
			lss_pkg::ST_COL: begin
				if (col_q == n_eff) begin
					state_d = lss_pkg::ST_STORE;
				end else if (mask_q[col_q[IW-1:0]]) begin
					state_d = lss_pkg::ST_FETCH;
				end
			end
			lss_pkg::ST_FETCH: state_d = lss_pkg::ST_MUL;
			lss_pkg::ST_MUL: begin
				if (k_q == 5'd0) state_d = lss_pkg::ST_ACC;
			end
			lss_pkg::ST_ACC: state_d = lss_pkg::ST_COL;
			lss_pkg::ST_STORE: begin
				if (mask_end && row_q == '0) state_d = lss_pkg::ST_DET;
				else state_d = lss_pkg::ST_MASK;
			end
			lss_pkg::ST_DET: begin
				if (rhs_mode_q) state_d = lss_pkg::ST_DIV;
				else if (acc_zero) state_d = lss_pkg::ST_SING;
				else state_d = lss_pkg::ST_MASK;
			end
			lss_pkg::ST_DIV: begin
				if (cnt_q == CW'(1)) state_d = lss_pkg::ST_EMIT;
			end
			lss_pkg::ST_EMIT: begin
				if (emit_last) state_d = lss_pkg::ST_IDLE;
				else state_d = lss_pkg::ST_MASK;
			end
			lss_pkg::ST_SING: state_d = lss_pkg::ST_IDLE;
			default: state_d = lss_pkg::ST_IDLE;
		endcase
	end

	// decoded outputs
	always_comb begin
		busy      = (state_q != lss_pkg::ST_IDLE);
		accept    = start && !busy;
		load_last = (ld_row_q == n_eff) && (ld_col_q == n_eff - NW'(1));
		if (ld_row_q == n_eff) begin
			ld_addr = RHS_BASE + AW'(ld_col_q);
		end else begin
			ld_addr = AW'(ld_row_q) * ROW_STEP + AW'(ld_col_q);
		end
		if (rhs_mode_q && col_q == NW'(repl_q)) begin
			rd_addr = RHS_BASE + AW'(row_q);
		end else begin
			rd_addr = AW'(row_q) * ROW_STEP + AW'(col_q);
		end
		restart = (state_q == lss_pkg::ST_DET && !rhs_mode_q && !acc_zero)
			|| (state_q == lss_pkg::ST_EMIT && !emit_last)
			|| (state_q == lss_pkg::ST_IDLE && accept && load_last);
		addend  = (k_q == 5'd31) ? ~mc : mc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= lss_pkg::ST_IDLE;
			size_q       <= lss_pkg::SIZE_RESET;
			ld_row_q     <= '0;
			ld_col_q     <= '0;
			result_valid <= 1'b0;
		end else begin
			state_q      <= state_d;
			result_valid <= (state_q == lss_pkg::ST_EMIT) || (state_q == lss_pkg::ST_SING);
			if (size_we) begin
				size_q   <= system_size;
				ld_row_q <= '0;
				ld_col_q <= '0;
			end else if (accept) begin
				if (load_last) begin
					ld_row_q <= '0;
					ld_col_q <= '0;
				end else if (ld_col_q == n_eff - NW'(1)) begin
					ld_col_q <= '0;
					ld_row_q <= ld_row_q + NW'(1);
				end else begin
					ld_col_q <= ld_col_q + NW'(1);
				end
			end
		end
	end

	// stores and fetch reads
	always_ff @(posedge clk) begin
		if (accept) elem_mem[ld_addr] <= value;
		if (state_q == lss_pkg::ST_STORE) minor_mem[mask_q] <= acc_q;
		if (state_q == lss_pkg::ST_FETCH) begin
			elem_rd_q  <= elem_mem[rd_addr];
			minor_rd_q <= minor_mem[sub_mask];
			sub_zero_q <= (sub_mask == '0);
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (restart) begin
			row_q  <= IW'(n_eff - NW'(1));
			mask_q <= M'(1);
		end
		case (state_q)
			lss_pkg::ST_IDLE: begin
				rhs_mode_q <= 1'b0;
				repl_q     <= '0;
			end
			lss_pkg::ST_MASK: begin
				if (pop_ok) begin
					acc_q <= '0;
					pos_q <= 1'b0;
					col_q <= '0;
				end else if (mask_end) begin
					row_q  <= row_q - IW'(1);
					mask_q <= M'(1);
				end else begin
					mask_q <= mask_q + M'(1);
				end
			end
			lss_pkg::ST_COL: begin
				if (col_q != n_eff && !mask_q[col_q[IW-1:0]]) col_q <= col_q + NW'(1);
				prod_q <= '0;
				k_q    <= 5'd31;
			end
			lss_pkg::ST_MUL: begin
				// msb of the element has negative weight
				if (elem_rd_q[k_q]) begin
					prod_q <= {prod_q[W-2:0], 1'b0} + addend + W'(k_q == 5'd31);
				end else begin
					prod_q <= {prod_q[W-2:0], 1'b0};
				end
				k_q <= k_q - 5'd1;
			end
			lss_pkg::ST_ACC: begin
				acc_q <= pos_q ? (acc_q - prod_q) : (acc_q + prod_q);
				pos_q <= ~pos_q;
				col_q <= col_q + NW'(1);
			end
			lss_pkg::ST_STORE: begin
				if (!(mask_end && row_q == '0)) begin
					if (mask_end) begin
						row_q  <= row_q - IW'(1);
						mask_q <= M'(1);
					end else begin
						mask_q <= mask_q + M'(1);
					end
				end
			end
			lss_pkg::ST_DET: begin
				if (!rhs_mode_q) begin
					den_q      <= acc_abs;
					den_neg_q  <= acc_q[W-1];
					rhs_mode_q <= 1'b1;
				end else begin
					num_q <= acc_abs << 16;
					neg_q <= acc_q[W-1] ^ den_neg_q;
				end
				rem_q <= '0;
				quo_q <= '0;
				big_q <= 1'b0;
				cnt_q <= CW'(W);
			end
			lss_pkg::ST_DIV: begin
				num_q <= num_q << 1;
				rem_q <= rem_ge ? (rem_sh - den_q) : rem_sh;
				quo_q <= {quo_q[30:0], rem_ge};
				big_q <= big_q | quo_q[31];
				cnt_q <= cnt_q - CW'(1);
			end
			lss_pkg::ST_EMIT: begin
				unknown_index <= 2'(repl_q);
				last          <= emit_last;
				if (neg_q) begin
					if (big_q || quo_q > 32'h8000_0000) begin
						solution <= 32'sh8000_0000;
						status   <= lss_pkg::STATUS_SATURATED;
					end else begin
						solution <= -$signed(quo_q);
						status   <= lss_pkg::STATUS_OK;
					end
				end else begin
					if (big_q || quo_q[31]) begin
						solution <= 32'sh7fff_ffff;
						status   <= lss_pkg::STATUS_SATURATED;
					end else begin
						solution <= $signed(quo_q);
						status   <= lss_pkg::STATUS_OK;
					end
				end
				repl_q <= repl_q + IW'(1);
			end
			lss_pkg::ST_SING: begin
				solution      <= '0;
				unknown_index <= '0;
				status        <= lss_pkg::STATUS_SINGULAR;
				last          <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |-> !busy)
		else $error("busy after final result");

	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> busy)
		else $error("solve ended before final result");

	a_singular: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == lss_pkg::STATUS_SINGULAR |-> last && solution == 0)
		else $error("bad singular result");

	a_start_solve: assert property (@(posedge clk) disable iff (!arst_n)
		accept && load_last && !size_we |=> busy)
		else $error("solve not started after final value");

endmodule
